FILE: hdl/htd_pkg.sv
// Shared types and constants for the header/tail deframer.
// No dependencies; used by htd_regs, htd_core, the top level and the testbench.
package htd_pkg;

    // Register indexes on the configuration port (byte address / 8)
    localparam logic [1:0] REG_HEAD_LEN = 2'd0;
    localparam logic [1:0] REG_HEAD_PAT = 2'd1;
    localparam logic [1:0] REG_TAIL_LEN = 2'd2;
    localparam logic [1:0] REG_TAIL_PAT = 2'd3;

    // Reset values of the registers
    localparam logic [3:0]  HEAD_LEN_RST = 4'd0;
    localparam logic [63:0] HEAD_PAT_RST = 64'd0;
    localparam logic [3:0]  TAIL_LEN_RST = 4'd1;
    localparam logic [63:0] TAIL_PAT_RST = 64'h0A;   // newline

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [3:0]  head_len;
        logic [63:0] head_pat;
        logic [3:0]  tail_len;
        logic [63:0] tail_pat;
    } cfg_t;

endpackage

FILE: hdl/htd_regs.sv
// APB-style register file for the deframer configuration.
// Depends on htd_pkg (cfg_t, register indexes and reset values).
module htd_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output htd_pkg::cfg_t cfg
);

    htd_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_len <= htd_pkg::HEAD_LEN_RST;
            cfg_reg.head_pat <= htd_pkg::HEAD_PAT_RST;
            cfg_reg.tail_len <= htd_pkg::TAIL_LEN_RST;
            cfg_reg.tail_pat <= htd_pkg::TAIL_PAT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                htd_pkg::REG_HEAD_LEN: cfg_reg.head_len <= pwdata[3:0];
                htd_pkg::REG_HEAD_PAT: cfg_reg.head_pat <= pwdata;
                htd_pkg::REG_TAIL_LEN: cfg_reg.tail_len <= pwdata[3:0];
                htd_pkg::REG_TAIL_PAT: cfg_reg.tail_pat <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            htd_pkg::REG_HEAD_LEN: prdata = {60'd0, cfg_reg.head_len};
            htd_pkg::REG_HEAD_PAT: prdata = cfg_reg.head_pat;
            htd_pkg::REG_TAIL_LEN: prdata = {60'd0, cfg_reg.tail_len};
            htd_pkg::REG_TAIL_PAT: prdata = cfg_reg.tail_pat;
            default:               prdata = 64'd0;
        endcase
    end

endmodule

FILE: hdl/htd_in_reg.sv
// Input register: captures one received byte and holds it until the core takes it.
// No package dependencies.
module htd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       advance,
    output logic       step,
    output logic [7:0] byte_out
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_ready  = !valid_reg || advance;
    assign step     = valid_reg && advance;
    assign byte_out = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_in_byte;
        end
    end

endmodule

FILE: hdl/htd_core.sv
// Deframer core: hunt/body state, byte window, pattern compares and result register.
// Depends on htd_pkg (cfg_t).
module htd_core #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  htd_pkg::cfg_t cfg,
    input  logic          step,
    input  logic [7:0]    in_byte,
    output logic          advance,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_has_byte,
    output logic [7:0]    m_body_byte,
    output logic          m_packet_end
);

    localparam int FW = $clog2(MAX_DELIM_BYTES + 1);
    localparam int WW = 8 * MAX_DELIM_BYTES;
    localparam logic [FW-1:0] MAX_LEN = FW'(MAX_DELIM_BYTES);

    // byte mask covering the n lowest bytes of the window
    function automatic logic [WW-1:0] byte_mask(input logic [FW-1:0] n);
        logic [WW-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
            if (FW'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    logic          in_body_reg, in_body_next;
    logic [WW-1:0] win_reg, win_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic          out_valid_reg, has_byte_reg, packet_end_reg;
    logic [7:0]    body_byte_reg;

    logic [FW-1:0] hl, tl, fill_h, fill_c, fill_b;
    logic [WW-1:0] win_sh;
    logic          hunting, hmatch, emit, done;
    logic [7:0]    ob;

    assign advance      = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_has_byte   = has_byte_reg;
    assign m_body_byte  = body_byte_reg;
    assign m_packet_end = packet_end_reg;

    // clamp configured lengths to the window size; a zero tail length counts as one
    always_comb begin
        hl = (cfg.head_len > 4'(MAX_DELIM_BYTES)) ? MAX_LEN : FW'(cfg.head_len);
        if (cfg.tail_len == 4'd0) begin
            tl = FW'(1);
        end else if (cfg.tail_len > 4'(MAX_DELIM_BYTES)) begin
            tl = MAX_LEN;
        end else begin
            tl = FW'(cfg.tail_len);
        end
    end

    // header hunt: shift in, saturate fill, compare
    assign hunting = !in_body_reg && (hl != '0);
    assign win_sh  = (win_reg << 8) | WW'(in_byte);
    assign fill_h  = (fill_reg < hl) ? fill_reg + FW'(1) : hl;
    assign hmatch  = (fill_h == hl) &&
                     (((win_sh ^ cfg.head_pat[WW-1:0]) & byte_mask(hl)) == '0);

    // body: the byte falling out of the tail window is emitted
    assign fill_c = (fill_reg > tl) ? tl : fill_reg;
    assign emit   = (fill_c == tl);
    assign fill_b = emit ? fill_c : fill_c + FW'(1);
    assign done   = (fill_b == tl) &&
                    (((win_sh ^ cfg.tail_pat[WW-1:0]) & byte_mask(tl)) == '0);

    // select window byte at position tl-1
    always_comb begin
        ob = 8'd0;
        for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
            if (FW'(i) == tl - FW'(1)) begin
                ob = win_reg[8*i +: 8];
            end
        end
    end

    // next state
    always_comb begin
        in_body_next = in_body_reg;
        win_next     = win_reg;
        fill_next    = fill_reg;
        if (hunting) begin
            if (hmatch) begin
                in_body_next = 1'b1;
                win_next     = '0;
                fill_next    = '0;
            end else begin
                win_next  = win_sh;
                fill_next = fill_h;
            end
        end else if (done) begin
            in_body_next = 1'b0;
            win_next     = '0;
            fill_next    = '0;
        end else begin
            win_next  = win_sh;
            fill_next = fill_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg <= 1'b0;
            win_reg     <= '0;
            fill_reg    <= '0;
        end else if (step) begin
            in_body_reg <= in_body_next;
            win_reg     <= win_next;
            fill_reg    <= fill_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && !hunting && (emit || done);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step) begin
            has_byte_reg   <= emit;
            body_byte_reg  <= emit ? ob : 8'd0;
            packet_end_reg <= done;
        end
    end

endmodule

FILE: hdl/header_tail_deframer.sv
// Top level of the header/tail delimiter packet deframer.
// Depends on htd_pkg, htd_regs, htd_in_reg and htd_core.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_in_byte
//   m_        out        m_valid/m_ready    m_has_byte, m_body_byte, m_packet_end
//   apb       in         psel/penable       paddr, pwdata, prdata (regs at 8*i)
//
// One byte per cycle sustained while results are taken; the input register holds
// each accepted byte, and the window compare loads the result register from it
// once the result register is free.
// Bytes that give no result (header hunt, tail fill) just update the window.
// Synchronous active-low reset clears state; the default config has no header, so no hunt.
// A stalled result holds the core; the input register still takes one byte.
module header_tail_deframer #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_byte,
    output logic [7:0]  m_body_byte,
    output logic        m_packet_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    htd_pkg::cfg_t cfg;
    logic          advance;
    logic          step;
    logic [7:0]    core_byte;

    htd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    htd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .advance   (advance),
        .step      (step),
        .byte_out  (core_byte)
    );

    htd_core #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .step         (step),
        .in_byte      (core_byte),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_has_byte   (m_has_byte),
        .m_body_byte  (m_body_byte),
        .m_packet_end (m_packet_end)
    );

endmodule

FILE: hdl/htd_checker.sv
// Port-level checks for the deframer, bound to the top level.
// Depends only on the top-level ports.
module htd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_has_byte,
    input logic [7:0] m_body_byte,
    input logic       m_packet_end
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_has_byte) &&
        $stable(m_body_byte) && $stable(m_packet_end))
        else $error("result changed while stalled");

    // every result carries a byte or closes a packet
    a_out_meaning: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_has_byte || m_packet_end))
        else $error("empty result");

    // body byte is zero when no byte is carried
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_body_byte == 8'd0)
        else $error("body byte not zero");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind header_tail_deframer htd_checker u_htd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_has_byte   (m_has_byte),
    .m_body_byte  (m_body_byte),
    .m_packet_end (m_packet_end)
);

FILE: verif/tb.sv
// Testbench for header_tail_deframer: byte stream in, body bytes and packet ends out.
// Depends on htd_pkg and the header_tail_deframer RTL; runs stand-alone, self-checking
// against a built-in deframing predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] body_byte;
        logic       packet_end;
    } deframe_out_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_has_byte;
    logic [7:0]  m_body_byte;
    logic        m_packet_end;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Predictor copy of the registers and the deframer state
    logic [3:0]  cfg_head_len;
    logic [63:0] cfg_head_pat;
    logic [3:0]  cfg_tail_len;
    logic [63:0] cfg_tail_pat;
    logic        in_body;
    logic [63:0] held_bytes;
    logic [3:0]  held_count;

    deframe_out_t pending_out[$];
    deframe_out_t want;
    int errors = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;
    int rx_stall_left = 0;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;

    always #2 aclk = ~aclk;

    header_tail_deframer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_has_byte  (m_has_byte),
        .m_body_byte (m_body_byte),
        .m_packet_end(m_packet_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ---------------------------------------------------------------- predictor

    function automatic logic [3:0] clamp_len(logic [3:0] v, logic [3:0] lo);
        if (v < lo) return lo;
        if (v > 4'd8) return 4'd8;
        return v;
    endfunction

    function automatic logic [63:0] len_mask(logic [3:0] n);
        if (n >= 4'd8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Advance the deframer by one accepted byte, queue the result it causes
    function automatic void deframe_byte(logic [7:0] b);
        logic [3:0]   hl;
        logic [3:0]   tl;
        logic         emit;
        logic         done;
        logic [7:0]   ob;
        deframe_out_t res;
        hl = clamp_len(cfg_head_len, 4'd0);
        tl = clamp_len(cfg_tail_len, 4'd1);
        ob = 8'd0;

        // header hunt: every byte is dropped
        if (!in_body && hl != 4'd0) begin
            held_bytes = {held_bytes[55:0], b};
            if (held_count < hl) held_count++;
            if (held_count > hl) held_count = hl;
            if (held_count == hl &&
                (held_bytes & len_mask(hl)) == (cfg_head_pat & len_mask(hl))) begin
                in_body = 1'b1;
                held_bytes = '0;
                held_count = '0;
            end
            return;
        end

        // body: oldest held byte falls out once the tail window is full
        if (held_count > tl) held_count = tl;
        emit = (held_count == tl);
        if (emit) ob = 8'(held_bytes >> (8 * (tl - 1)));
        held_bytes = {held_bytes[55:0], b};
        if (!emit) held_count++;
        done = (held_count == tl) &&
               ((held_bytes & len_mask(tl)) == (cfg_tail_pat & len_mask(tl)));
        if (done) begin
            in_body = 1'b0;
            held_bytes = '0;
            held_count = '0;
        end
        if (emit || done) begin
            res.has_byte   = emit;
            res.body_byte  = ob;
            res.packet_end = done;
            pending_out = {pending_out, res};
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report(input string msg);
        if (errors < 10) $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v)
            report($sformatf("%s expected %0h got %0h", name, exp_v, got_v));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                report($sformatf("unexpected item has_byte=%0b body_byte=%0h packet_end=%0b",
                                 m_has_byte, m_body_byte, m_packet_end));
            end else begin
                want = pending_out.pop_front();
                check_field("has_byte", 8'(want.has_byte), 8'(m_has_byte));
                check_field("body_byte", want.body_byte, m_body_byte);
                check_field("packet_end", 8'(want.packet_end), 8'(m_packet_end));
            end
        end
    end

    // Watchdog: no handshake anywhere for too long ends the run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("header_tail_deframer test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result-side backpressure
    always @(negedge aclk) begin
        if (rx_calm) begin
            m_ready <= 1'b1;
        end else if (rx_stall_left != 0) begin
            m_ready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            rx_stall_left <= pick_gap();
        end
    end

    // Called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Send the oldest 'count' bytes of an n-byte pattern (newest byte in bits 7..0)
    task automatic send_pattern(input logic [63:0] pat, input int n, input int count);
        for (int k = 0; k < count; k++)
            send_byte(pat[8 * (n - 1 - k) +: 8]);
    endtask

    // Drain all results, then give the pipeline time to swallow silent bytes
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            htd_pkg::REG_HEAD_LEN: cfg_head_len = value[3:0];
            htd_pkg::REG_HEAD_PAT: cfg_head_pat = value;
            htd_pkg::REG_TAIL_LEN: cfg_tail_len = value[3:0];
            htd_pkg::REG_TAIL_PAT: cfg_tail_pat = value;
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_config(input logic [3:0] hl, input logic [63:0] hp,
                                input logic [3:0] tl, input logic [63:0] tp);
        reg_write(htd_pkg::REG_HEAD_LEN, 64'(hl));
        reg_write(htd_pkg::REG_HEAD_PAT, hp);
        reg_write(htd_pkg::REG_TAIL_LEN, 64'(tl));
        reg_write(htd_pkg::REG_TAIL_PAT, tp);
    endtask

    // random pattern with frequent repeated bytes so occurrences overlap
    function automatic logic [63:0] rand_pattern();
        logic [63:0] p;
        for (int i = 0; i < 8; i++)
            p[8 * i +: 8] = ($urandom_range(0, 3) == 0) ? 8'h5A : 8'($urandom);
        return p;
    endfunction

    // ---------------------------------------------------------------- tests

    // Reset config: no header, newline tail; includes empty packets
    task automatic test_default_newline();
        send_byte(8'h41);
        send_byte(8'h0A);
        send_byte(8'h0A);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h0A);
    endtask

    // Header hunt with noise; header and tail both complete on overlapping bytes
    task automatic test_header_overlap();
        settle();
        write_config(4'd2, 64'h55AA, 4'd2, 64'h0D0A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0D);
        send_byte(8'h0D);
        send_byte(8'h0A);
    endtask

    // Shrink the tail mid-packet: older held bytes vanish; zero length acts as one
    task automatic test_tail_resize();
        settle();
        reg_write(htd_pkg::REG_HEAD_LEN, 64'd0);
        reg_write(htd_pkg::REG_TAIL_LEN, 64'd3);
        reg_write(htd_pkg::REG_TAIL_PAT, 64'h010203);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h44);
        settle();
        reg_write(htd_pkg::REG_TAIL_LEN, 64'd0);
        send_byte(8'h03);
    endtask

    // Phases of random config, mostly well-formed packets with random content
    task automatic test_random_phases();
        int base;
        int r;
        int n;
        int k;
        logic [3:0] hl;
        logic [3:0] tl;
        int hl_eff;
        int tl_eff;
        for (int p = 0; p < 12; p++) begin
            settle();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            case (p)
                0: begin hl = 4'd0;  tl = 4'd1;  end
                1: begin hl = 4'd8;  tl = 4'd8;  end
                2: begin hl = 4'd15; tl = 4'd0;  end
                3: begin hl = 4'd9;  tl = 4'd15; end
                default: begin
                    hl = 4'($urandom_range(0, 15));
                    tl = 4'($urandom_range(0, 15));
                end
            endcase
            write_config(hl, rand_pattern(), tl, rand_pattern());
            hl_eff = int'(clamp_len(cfg_head_len, 4'd0));
            tl_eff = int'(clamp_len(cfg_tail_len, 4'd1));
            base = bytes_sent;
            while (bytes_sent - base < 75) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    // line noise
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                end else if (r == 1 && hl_eff > 1) begin
                    // broken header
                    send_pattern(cfg_head_pat, hl_eff, $urandom_range(1, hl_eff - 1));
                    send_byte(8'($urandom));
                end else begin
                    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
                    send_pattern(cfg_head_pat, hl_eff, hl_eff);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 6);
                    repeat (n) begin
                        k = $urandom_range(0, 7);
                        case ($urandom_range(0, 3))
                            0: send_byte(cfg_tail_pat[8 * k +: 8]);
                            1: send_byte(cfg_head_pat[8 * k +: 8]);
                            default: send_byte(8'($urandom));
                        endcase
                    end
                    send_pattern(cfg_tail_pat, tl_eff, tl_eff);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'd0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_head_len = htd_pkg::HEAD_LEN_RST;
        cfg_head_pat = htd_pkg::HEAD_PAT_RST;
        cfg_tail_len = htd_pkg::TAIL_LEN_RST;
        cfg_tail_pat = htd_pkg::TAIL_PAT_RST;
        in_body = 1'b0;
        held_bytes = '0;
        held_count = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_default_newline();
        test_header_overlap();
        test_tail_resize();
        test_random_phases();

        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_out.size() == 0)
            $display("header_tail_deframer test passed");
        else
            $display("header_tail_deframer test failed");
        $finish;
    end

endmodule
